// ===== rtl/planar_3prpr_inverse_kinematics_unit_macros.svh =====
// Assertion macros for the planar 3-PRPR inverse kinematics unit.
// Expects signals clk and arst_n in the scope of use.
`ifndef PLANAR_3PRPR_INVERSE_KINEMATICS_UNIT_MACROS_SVH
`define PLANAR_3PRPR_INVERSE_KINEMATICS_UNIT_MACROS_SVH

// Clocked property, off while in reset.
`define P3IK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold.
`define P3IK_ASSERT_NEVER(label, cond, msg) \
	`P3IK_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/p3ik_pkg.sv =====
// Shared types, widths and constants of the 3-PRPR inverse kinematics unit.
// No dependencies.
`default_nettype none
package p3ik_pkg;

	localparam int COORD_WIDTH_DEF  = 16;
	localparam int ANGLE_WIDTH_DEF  = 16;

	localparam int JOINT_W          = 16;
	localparam int FRAC_W           = 13;
	localparam int LEN_W            = 16;
	localparam int BASE_W           = 18;
	localparam int CS_W             = 33;
	localparam int Z_W              = 18;
	localparam int PROD_W           = CS_W + JOINT_W;
	localparam int ROT_W            = PROD_W - 30 + 1;
	localparam int SQ_W             = 33;
	localparam int ROOT_W           = 17;

	localparam int CORDIC_STEPS     = 16;
	localparam int CORDIC_PER_STAGE = 2;
	localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
	localparam int SQRT_PER_STAGE   = 3;
	localparam int SQRT_STAGES      = (ROOT_W + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
	localparam int LEG_STAGES       = 3 + SQRT_STAGES;

	localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic [ROOT_W-1:0]      LEN_OVER    = 17'd65536;
	localparam logic [47:0]            MIN_LEN_RST = 48'd1760963461530;
	localparam logic [47:0]            MAX_LEN_RST = 48'd21110086374195;

	typedef enum logic [2:0] {
		REG_PJ_A,
		REG_PJ_B,
		REG_PJ_C,
		REG_RAIL_A,
		REG_RAIL_B,
		REG_RAIL_C,
		REG_MIN_LEN,
		REG_MAX_LEN
	} cfg_index_t;

	function automatic logic signed [Z_W-1:0] atan_unit(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0:       r = 18'sd8192;
			1:       r = 18'sd4836;
			2:       r = 18'sd2555;
			3:       r = 18'sd1297;
			4:       r = 18'sd651;
			5:       r = 18'sd326;
			6:       r = 18'sd163;
			7:       r = 18'sd81;
			8:       r = 18'sd41;
			9:       r = 18'sd20;
			10:      r = 18'sd10;
			11:      r = 18'sd5;
			12:      r = 18'sd3;
			13:      r = 18'sd1;
			14:      r = 18'sd1;
			default: r = 18'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/p3ik_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cosine and sine in Q2.30.
// Carries a side payload alongside; depends on p3ik_pkg.
`default_nettype none
module p3ik_cordic import p3ik_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic [CORDIC_STAGES-1:0] en,
	input  logic signed [Z_W-1:0]    z_in,
	input  logic                     flip_in,
	input  logic [SIDE_W-1:0]        side_in,
	output logic signed [CS_W-1:0]   cos_out,
	output logic signed [CS_W-1:0]   sin_out,
	output logic [SIDE_W-1:0]        side_out
);

	logic signed [CS_W-1:0] x_s    [CORDIC_STAGES];
	logic signed [CS_W-1:0] y_s    [CORDIC_STAGES];
	logic signed [Z_W-1:0]  z_s    [CORDIC_STAGES];
	logic                   flip_s [CORDIC_STAGES];
	logic [SIDE_W-1:0]      side_s [CORDIC_STAGES];

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		logic signed [CS_W-1:0] x_i, y_i, xt, yt, dx, dy;
		logic signed [Z_W-1:0]  z_i, zt;
		logic                   flip_i;
		logic [SIDE_W-1:0]      side_i;

		if (g == 0) begin : g_first
			assign x_i    = CORDIC_GAIN;
			assign y_i    = '0;
			assign z_i    = z_in;
			assign flip_i = flip_in;
			assign side_i = side_in;
		end else begin : g_next
			assign x_i    = x_s[g-1];
			assign y_i    = y_s[g-1];
			assign z_i    = z_s[g-1];
			assign flip_i = flip_s[g-1];
			assign side_i = side_s[g-1];
		end

		always_comb begin
			xt = x_i;
			yt = y_i;
			zt = z_i;
			dx = '0;
			dy = '0;
			for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
				dx = yt >>> (g * CORDIC_PER_STAGE + j);
				dy = xt >>> (g * CORDIC_PER_STAGE + j);
				if (!zt[Z_W-1]) begin
					xt = xt - dx;
					yt = yt + dy;
					zt = zt - atan_unit(g * CORDIC_PER_STAGE + j);
				end else begin
					xt = xt + dx;
					yt = yt - dy;
					zt = zt + atan_unit(g * CORDIC_PER_STAGE + j);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				x_s[g]    <= xt;
				y_s[g]    <= yt;
				z_s[g]    <= zt;
				flip_s[g] <= flip_i;
				side_s[g] <= side_i;
			end
		end
	end

	assign cos_out  = flip_s[CORDIC_STAGES-1] ? -x_s[CORDIC_STAGES-1] : x_s[CORDIC_STAGES-1];
	assign sin_out  = flip_s[CORDIC_STAGES-1] ? -y_s[CORDIC_STAGES-1] : y_s[CORDIC_STAGES-1];
	assign side_out = side_s[CORDIC_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/p3ik_sqrt.sv =====
// Pipelined digit-by-digit integer square root, several digits per stage.
// Depends on p3ik_pkg.
`default_nettype none
module p3ik_sqrt import p3ik_pkg::*; (
	input  logic                   clk,
	input  logic [SQRT_STAGES-1:0] en,
	input  logic [SQ_W-1:0]        val_in,
	input  logic                   big_in,
	output logic [ROOT_W-1:0]      len_out
);

	localparam int RW = ROOT_W + 3;
	localparam int VW = 2 * ROOT_W;

	logic [VW-1:0]     v_s    [SQRT_STAGES];
	logic [RW-1:0]     rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [SQRT_STAGES];
	logic              big_s  [SQRT_STAGES];

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		logic [VW-1:0]     v_i, vt;
		logic [RW-1:0]     rem_i, remt, r2, trial;
		logic [ROOT_W-1:0] root_i, roott;
		logic              big_i;

		if (g == 0) begin : g_first
			assign v_i    = VW'(val_in);
			assign rem_i  = '0;
			assign root_i = '0;
			assign big_i  = big_in;
		end else begin : g_next
			assign v_i    = v_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign root_i = root_s[g-1];
			assign big_i  = big_s[g-1];
		end

		always_comb begin
			vt    = v_i;
			remt  = rem_i;
			roott = root_i;
			r2    = '0;
			trial = '0;
			for (int j = 0; j < SQRT_PER_STAGE; j++) begin
				if (g * SQRT_PER_STAGE + j < ROOT_W) begin
					r2    = {remt[RW-3:0], vt[VW-1:VW-2]};
					trial = RW'({roott, 2'b01});
					if (r2 >= trial) begin
						remt  = r2 - trial;
						roott = {roott[ROOT_W-2:0], 1'b1};
					end else begin
						remt  = r2;
						roott = {roott[ROOT_W-2:0], 1'b0};
					end
					vt = {vt[VW-3:0], 2'b00};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				v_s[g]    <= vt;
				rem_s[g]  <= remt;
				root_s[g] <= roott;
				big_s[g]  <= big_i;
			end
		end
	end

	assign len_out = big_s[SQRT_STAGES-1] ? LEN_OVER : root_s[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/p3ik_leg.sv =====
// One leg: platform joint rotation, offset to the base joint, squared distance
// and square root. Depends on p3ik_pkg and p3ik_sqrt.
`default_nettype none
module p3ik_leg import p3ik_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic [LEG_STAGES-1:0]         en,
	input  logic signed [CS_W-1:0]        cos_in,
	input  logic signed [CS_W-1:0]        sin_in,
	input  logic signed [JOINT_W-1:0]     jx,
	input  logic signed [JOINT_W-1:0]     jy,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [BASE_W-1:0]      bx,
	input  logic signed [BASE_W-1:0]      by,
	output logic [ROOT_W-1:0]             len
);

	localparam int EW = ((ROT_W > COORD_WIDTH) ? ROT_W : COORD_WIDTH) + 1;
	localparam int DW = EW + 1;
	localparam logic signed [PROD_W:0] ROT_HALF = (PROD_W + 1)'(1) <<< 29;

	logic signed [PROD_W-1:0]      cjx_s1, sjy_s1, sjx_s1, cjy_s1;
	logic signed [COORD_WIDTH-1:0] px_s1, py_s1;
	logic signed [BASE_W-1:0]      bx_s1, by_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cjx_s1 <= PROD_W'(cos_in) * PROD_W'(jx);
			sjy_s1 <= PROD_W'(sin_in) * PROD_W'(jy);
			sjx_s1 <= PROD_W'(sin_in) * PROD_W'(jx);
			cjy_s1 <= PROD_W'(cos_in) * PROD_W'(jy);
			px_s1  <= px;
			py_s1  <= py;
			bx_s1  <= bx;
			by_s1  <= by;
		end
	end

	logic signed [PROD_W:0] rx, ry;
	logic signed [EW-1:0]   ex, ey;
	logic signed [DW-1:0]   dxv, dyv;
	logic [DW-1:0]          adx, ady;

	always_comb begin
		rx  = (PROD_W + 1)'(cjx_s1) - (PROD_W + 1)'(sjy_s1) + ROT_HALF;
		ry  = (PROD_W + 1)'(sjx_s1) + (PROD_W + 1)'(cjy_s1) + ROT_HALF;
		ex  = EW'($signed(rx[PROD_W:30])) + EW'(px_s1);
		ey  = EW'($signed(ry[PROD_W:30])) + EW'(py_s1);
		dxv = DW'(ex) - DW'(bx_s1);
		dyv = DW'(ey) - DW'(by_s1);
		adx = dxv[DW-1] ? DW'(-dxv) : DW'(dxv);
		ady = dyv[DW-1] ? DW'(-dyv) : DW'(dyv);
	end

	logic [LEN_W-1:0] adx_s2, ady_s2;
	logic             big_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			adx_s2 <= adx[LEN_W-1:0];
			ady_s2 <= ady[LEN_W-1:0];
			big_s2 <= (|adx[DW-1:LEN_W]) || (|ady[DW-1:LEN_W]);
		end
	end

	logic [SQ_W-1:0] sq_s3;
	logic            big_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sq_s3  <= SQ_W'(adx_s2) * SQ_W'(adx_s2) + SQ_W'(ady_s2) * SQ_W'(ady_s2);
			big_s3 <= big_s2;
		end
	end

	p3ik_sqrt u_sqrt (
		.clk     (clk),
		.en      (en[LEG_STAGES-1:3]),
		.val_in  (sq_s3),
		.big_in  (big_s3),
		.len_out (len)
	);

endmodule
`default_nettype wire

// ===== rtl/planar_3prpr_inverse_kinematics_unit.sv =====
// Planar 3-PRPR inverse kinematics: three leg lengths and a limit flag per pose.
// Top level; depends on p3ik_pkg, p3ik_cordic, p3ik_leg and the macros header.
//
// Usage:
//  - Input channel in_valid/in_ready carries one pose request: pose_x, pose_y,
//    pose_angle and the three rail fractions.
//  - Output channel out_valid/out_ready returns leg_length_a/b/c (Q4.12,
//    saturated at 65535) and limits_violated.
//  - Registers are written through wr_en/wr_index/wr_data while no request is
//    in flight; each write takes effect at the next clock edge.
//  - The pipeline has 19 register stages: one input stage, eight CORDIC
//    stages of two iterations, three arithmetic stages per leg, six square
//    root stages of up to three digits, and one output stage.
//  - Throughput is one request per cycle while the output is not stalled;
//    every stage has its own valid bit.
//  - When out_ready is low, the output holds and upstream stages keep filling
//    empty slots; in_ready drops only when every stage holds a request.
//  - arst_n clears all valid bits and loads register reset values; the block
//    accepts requests from the first edge after reset is released.
`default_nettype none
`include "planar_3prpr_inverse_kinematics_unit_macros.svh"
module planar_3prpr_inverse_kinematics_unit import p3ik_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] pose_x,
	input  logic signed [COORD_WIDTH-1:0] pose_y,
	input  logic signed [ANGLE_WIDTH-1:0] pose_angle,
	input  logic [FRAC_W-1:0]             rail_frac_a,
	input  logic [FRAC_W-1:0]             rail_frac_b,
	input  logic [FRAC_W-1:0]             rail_frac_c,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [LEN_W-1:0]              leg_length_a,
	output logic [LEN_W-1:0]              leg_length_b,
	output logic [LEN_W-1:0]              leg_length_c,
	output logic                          limits_violated,
	input  logic                          wr_en,
	input  logic [2:0]                    wr_index,
	input  logic [63:0]                   wr_data
);

	localparam int NST    = 1 + CORDIC_STAGES + LEG_STAGES + 1;
	localparam int SIDE_W = 2 * COORD_WIDTH + 6 * BASE_W;

	logic [31:0] pj_q   [3];
	logic [63:0] rail_q [3];
	logic [47:0] min_q, max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				pj_q[k]   <= '0;
				rail_q[k] <= '0;
			end
			min_q <= MIN_LEN_RST;
			max_q <= MAX_LEN_RST;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				REG_PJ_A:    pj_q[0]   <= wr_data[31:0];
				REG_PJ_B:    pj_q[1]   <= wr_data[31:0];
				REG_PJ_C:    pj_q[2]   <= wr_data[31:0];
				REG_RAIL_A:  rail_q[0] <= wr_data;
				REG_RAIL_B:  rail_q[1] <= wr_data;
				REG_RAIL_C:  rail_q[2] <= wr_data;
				REG_MIN_LEN: min_q     <= wr_data[47:0];
				REG_MAX_LEN: max_q     <= wr_data[47:0];
			endcase
		end
	end

	logic [NST-1:0] vld_s;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !vld_s[NST-1] || out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NST-1];

	logic signed [15:0] a16;
	if (ANGLE_WIDTH >= 16) begin : g_angle_down
		assign a16 = pose_angle[ANGLE_WIDTH-1 -: 16];
	end else begin : g_angle_up
		assign a16 = {pose_angle, {(16 - ANGLE_WIDTH){1'b0}}};
	end

	logic              flip;
	logic signed [15:0] zn;
	assign flip = (a16 > 16'sd16384) || (a16 < -16'sd16384);
	assign zn   = flip ? {~a16[15], a16[14:0]} : a16;

	logic [FRAC_W-1:0]        frac [3];
	logic signed [29:0]       pbx [3], pby [3];
	logic signed [BASE_W-1:0] bx [3], by [3];

	assign frac[0] = rail_frac_a;
	assign frac[1] = rail_frac_b;
	assign frac[2] = rail_frac_c;

	for (genvar k = 0; k < 3; k++) begin : g_base
		assign pbx[k] = $signed({1'b0, frac[k]}) * $signed(rail_q[k][31:16]) + 30'sd2048;
		assign pby[k] = $signed({1'b0, frac[k]}) * $signed(rail_q[k][15:0]) + 30'sd2048;
		assign bx[k]  = BASE_W'($signed(rail_q[k][63:48])) + $signed(pbx[k][29:12]);
		assign by[k]  = BASE_W'($signed(rail_q[k][47:32])) + $signed(pby[k][29:12]);
	end

	logic signed [Z_W-1:0] z_s1;
	logic                  flip_s1;
	logic [SIDE_W-1:0]     side_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			z_s1    <= Z_W'(zn);
			flip_s1 <= flip;
			side_s1 <= {pose_x, pose_y, bx[0], by[0], bx[1], by[1], bx[2], by[2]};
		end
	end

	logic signed [CS_W-1:0] cos_c, sin_c;
	logic [SIDE_W-1:0]      side_c;

	p3ik_cordic #(
		.SIDE_W (SIDE_W)
	) u_cordic (
		.clk      (clk),
		.en       (en[CORDIC_STAGES:1]),
		.z_in     (z_s1),
		.flip_in  (flip_s1),
		.side_in  (side_s1),
		.cos_out  (cos_c),
		.sin_out  (sin_c),
		.side_out (side_c)
	);

	logic signed [COORD_WIDTH-1:0] px_c, py_c;
	assign px_c = $signed(side_c[SIDE_W-1 -: COORD_WIDTH]);
	assign py_c = $signed(side_c[SIDE_W-COORD_WIDTH-1 -: COORD_WIDTH]);

	logic [ROOT_W-1:0] len [3];

	for (genvar k = 0; k < 3; k++) begin : g_leg
		p3ik_leg #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_leg (
			.clk    (clk),
			.en     (en[CORDIC_STAGES+LEG_STAGES:CORDIC_STAGES+1]),
			.cos_in (cos_c),
			.sin_in (sin_c),
			.jx     ($signed(pj_q[k][31:16])),
			.jy     ($signed(pj_q[k][15:0])),
			.px     (px_c),
			.py     (py_c),
			.bx     ($signed(side_c[(6-2*k)*BASE_W-1 -: BASE_W])),
			.by     ($signed(side_c[(5-2*k)*BASE_W-1 -: BASE_W])),
			.len    (len[k])
		);
	end

	logic             viol;
	logic [LEN_W-1:0] sat [3];

	always_comb begin
		viol = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if ((len[k] < ROOT_W'(min_q[(2-k)*16 +: 16]))
				|| (len[k] > ROOT_W'(max_q[(2-k)*16 +: 16]))) begin
				viol = 1'b1;
			end
			sat[k] = len[k][ROOT_W-1] ? {LEN_W{1'b1}} : len[k][LEN_W-1:0];
		end
	end

	logic [LEN_W-1:0] len_s19 [3];
	logic             viol_s19;

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			for (int k = 0; k < 3; k++) begin
				len_s19[k] <= sat[k];
			end
			viol_s19 <= viol;
		end
	end

	assign leg_length_a    = len_s19[0];
	assign leg_length_b    = len_s19[1];
	assign leg_length_c    = len_s19[2];
	assign limits_violated = viol_s19;

	`P3IK_ASSERT(a_ready_when_first_empty, !vld_s[0] |-> in_ready, "input stalled with first stage empty")
	`P3IK_ASSERT(a_accept_fills_first, (in_valid && in_ready) |=> vld_s[0], "accepted request lost at first stage")
	`P3IK_ASSERT_NEVER(a_drain_no_ghost, $past(out_valid && out_ready && !vld_s[NST-2]) && out_valid && !$past(!arst_n), "result repeated after drain")

endmodule
`default_nettype wire

// ===== dv/tb_planar_3prpr_inverse_kinematics_unit.sv =====
// Testbench for the planar 3-PRPR inverse kinematics unit: directed poses, then random ones.
// Predicts leg lengths and the limit flag in place; depends on p3ik_pkg and the DUT.
`default_nettype none
module tb_planar_3prpr_inverse_kinematics_unit;
	import p3ik_pkg::*;

	typedef struct packed {
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] ang;
		logic [12:0] fa;
		logic [12:0] fb;
		logic [12:0] fc;
	} pose_t;

	typedef struct packed {
		logic [15:0] la;
		logic [15:0] lb;
		logic [15:0] lc;
		logic        viol;
	} legs_t;

	typedef struct {
		pose_t p;
		logic  chk;
		legs_t r;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] pose_x = 0, pose_y = 0, pose_angle = 0;
	logic [12:0] rail_frac_a = 0, rail_frac_b = 0, rail_frac_c = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [15:0] leg_length_a, leg_length_b, leg_length_c;
	logic limits_violated;
	logic wr_en = 0;
	logic [2:0] wr_index = 0;
	logic [63:0] wr_data = 0;

	logic [31:0] joint_cfg [3];
	logic [63:0] rail_cfg [3];
	logic [47:0] min_cfg, max_cfg;

	legs_t expected_legs [$];
	int errors = 0;
	int n_results = 0;
	int n_poses = 0;
	int out_wait = 0;
	longint cycles = 0;

	planar_3prpr_inverse_kinematics_unit DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("timeout at %0t", $time);
			$display("status: fail");
			$finish;
		end
	end

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint isqrt(longint v);
		longint r = 0, b = 64'sd1 <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else
				r = r >>> 1;
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic legs_t predict_legs(pose_t p);
		longint a, x, y, z, dx, dy, c, s;
		longint jx, jy, sx, sy, vx, vy, f, bx, by, ex, ey, l, lo, hi;
		logic [12:0] fr [3];
		logic [15:0] len [3];
		bit flip;
		legs_t r;
		a = longint'($signed(p.ang));
		flip = 0;
		if (a > 16384 || a < -16384) begin
			a = longint'($signed(16'(a - 32768)));
			flip = 1;
		end
		x = 652032874; y = 0; z = a;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = fshr(y, i); dy = fshr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_unit(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_unit(i));
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		fr[0] = p.fa; fr[1] = p.fb; fr[2] = p.fc;
		r.viol = 0;
		for (int k = 0; k < 3; k++) begin
			jx = longint'($signed(joint_cfg[k][31:16]));
			jy = longint'($signed(joint_cfg[k][15:0]));
			sx = longint'($signed(rail_cfg[k][63:48]));
			sy = longint'($signed(rail_cfg[k][47:32]));
			vx = longint'($signed(rail_cfg[k][31:16]));
			vy = longint'($signed(rail_cfg[k][15:0]));
			f = longint'(fr[k]);
			bx = sx + fshr(f * vx + 2048, 12);
			by = sy + fshr(f * vy + 2048, 12);
			ex = fshr(c * jx - s * jy + (64'sd1 <<< 29), 30) + longint'($signed(p.px));
			ey = fshr(s * jx + c * jy + (64'sd1 <<< 29), 30) + longint'($signed(p.py));
			dx = ex - bx; dy = ey - by;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			l = (dx >= 65536 || dy >= 65536) ? 65536 : isqrt(dx * dx + dy * dy);
			lo = longint'(min_cfg[(2 - k) * 16 +: 16]);
			hi = longint'(max_cfg[(2 - k) * 16 +: 16]);
			if (l < lo || l > hi) r.viol = 1;
			len[k] = (l > 65535) ? 16'hFFFF : 16'(l);
		end
		r.la = len[0]; r.lb = len[1]; r.lc = len[2];
		return r;
	endfunction

	task automatic write_reg(cfg_index_t idx, logic [63:0] d);
		wr_en <= 1; wr_index <= idx; wr_data <= d;
		@(posedge clk);
		wr_en <= 0;
		case (idx)
			REG_PJ_A, REG_PJ_B, REG_PJ_C: joint_cfg[int'(idx)] = d[31:0];
			REG_RAIL_A, REG_RAIL_B, REG_RAIL_C: rail_cfg[int'(idx) - 3] = d;
			REG_MIN_LEN: min_cfg = d[47:0];
			default: max_cfg = d[47:0];
		endcase
		@(posedge clk);
	endtask

	task automatic send_pose(pose_t p, logic chk, legs_t r);
		int n;
		legs_t e;
		n = $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		{pose_x, pose_y, pose_angle} <= {p.px, p.py, p.ang};
		{rail_frac_a, rail_frac_b, rail_frac_c} <= {p.fa, p.fb, p.fc};
		do @(posedge clk); while (!in_ready);
		e = predict_legs(p);
		if (chk && e != r) begin
			$display("%0t table row disagrees: expected %h actual %h", $time, r, e);
			errors++;
		end
		expected_legs.push_back(e);
		n_poses++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_legs.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	function automatic pose_t rand_pose(bit wide);
		pose_t p;
		p.px = $urandom; p.py = $urandom; p.ang = $urandom;
		if (!wide) begin
			p.px = 16'($signed(p.px) >>> 3);
			p.py = 16'($signed(p.py) >>> 3);
		end
		p.fa = $urandom_range(0, 8191) % ($urandom_range(0, 3) == 0 ? 8192 : 4097);
		p.fb = $urandom_range(0, 8191) % ($urandom_range(0, 3) == 0 ? 8192 : 4097);
		p.fc = $urandom_range(0, 8191) % ($urandom_range(0, 3) == 0 ? 8192 : 4097);
		return p;
	endfunction

	always @(posedge clk) begin
		legs_t got, e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {leg_length_a, leg_length_b, leg_length_c, limits_violated};
				if (expected_legs.size() == 0) begin
					$display("%0t unexpected result: actual %h", $time, got);
					errors++;
				end else begin
					e = expected_legs.pop_front();
					n_results++;
					if (got != e) begin
						$display("%0t mismatch: expected %h actual %h", $time, e, got);
						errors++;
					end
				end
				out_wait = $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
			end
			if (out_wait > 0) begin
				out_wait--;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	row_t rows [$];

	initial begin
		row_t t;
		legs_t z;
		joint_cfg = '{0, 0, 0};
		rail_cfg = '{0, 0, 0};
		min_cfg = MIN_LEN_RST;
		max_cfg = MAX_LEN_RST;
		z = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// after reset, all joints at origin: zero lengths, below minimum
		t = '{'{16'h0, 16'h0, 16'h0, 13'd0, 13'd0, 13'd0}, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}};
		rows.push_back(t);
		t = '{'{16'h1000, 16'h0, 16'h0, 13'd0, 13'd0, 13'd0}, 1'b1,
			'{16'd4096, 16'd4096, 16'd4096, 1'b0}};
		rows.push_back(t);
		t = '{'{16'h0, 16'h7FFF, 16'h8000, 13'd4096, 13'd8191, 13'd0}, 1'b1,
			'{16'd32767, 16'd32767, 16'd32767, 1'b1}};
		rows.push_back(t);
		t = '{'{16'h8000, 16'h0, 16'h7FFF, 13'd8191, 13'd1, 13'd4096}, 1'b1,
			'{16'd32768, 16'd32768, 16'd32768, 1'b1}};
		rows.push_back(t);
		foreach (rows[i]) send_pose(rows[i].p, rows[i].chk, rows[i].r);
		drain();

		write_reg(REG_PJ_A, 32'h1000_0000);
		write_reg(REG_PJ_B, 32'hF000_0800);
		write_reg(REG_PJ_C, 32'h0000_F000);
		write_reg(REG_RAIL_A, 64'h8000_8000_7FFF_7FFF);
		write_reg(REG_RAIL_B, 64'h2000_0000_0000_0000);
		write_reg(REG_RAIL_C, 64'hE000_1000_4000_C000);
		for (int i = 0; i < 16; i++)
			send_pose('{16'(i * 4096 - 32768), 16'(32767 - i * 4096), 16'(i * 8192),
				13'(i * 512), i[0] ? 13'd8191 : 13'd4096, 13'd0}, 1'b0, z);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			for (int k = 0; k < 3; k++)
				write_reg(cfg_index_t'(k), (ph == 5) ? 32'h7FFF_8000 : 32'($urandom));
			for (int k = 0; k < 3; k++)
				write_reg(cfg_index_t'(k + 3), (ph == 4) ? 64'hFFFF_FFFF_FFFF_FFFF :
					{$urandom, $urandom} & (ph[0] ? 64'hFFFF_FFFF_FFFF_FFFF
						: 64'h1FFF_1FFF_1FFF_1FFF));
			write_reg(REG_MIN_LEN, ph == 0 ? 48'h0 : ph == 5 ? 48'hFFFF_FFFF_FFFF
				: {$urandom, $urandom} & 48'h3FFF_3FFF_3FFF);
			write_reg(REG_MAX_LEN, ph == 0 ? 48'hFFFF_FFFF_FFFF : ph == 5 ? 48'h0
				: {$urandom, $urandom} | 48'h8000_8000_8000);
			for (int i = 0; i < 270; i++)
				send_pose(rand_pose($urandom_range(0, 1)), 1'b0, z);
			drain();
		end
		$display("covered %0d poses, %0d results, over eight register settings",
			n_poses, n_results);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
